@@ hw/rtl/gab_pkg.sv @@
// Shared types and codes for the scaled matrix product block.
// No dependencies; imported by gab_ram users and the top level.
package gab_pkg;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_LOAD_C = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic [2:0] REG_ALPHA  = 3'd0;
  localparam logic [2:0] REG_BETA   = 3'd1;
  localparam logic [2:0] REG_ROWS   = 3'd2;
  localparam logic [2:0] REG_COLS   = 3'd3;
  localparam logic [2:0] REG_INNER  = 3'd4;
  localparam logic [2:0] REG_CMODE  = 3'd5;
  localparam logic [2:0] REG_LAYOUT = 3'd6;

  // C broadcast modes
  localparam logic [2:0] CM_NONE   = 3'd0;
  localparam logic [2:0] CM_SCALAR = 3'd1;
  localparam logic [2:0] CM_ROW    = 3'd2;
  localparam logic [2:0] CM_FULL   = 3'd3;
  localparam logic [2:0] CM_COL    = 3'd4;

  // Layout flag bit positions
  localparam int unsigned LAY_A_T   = 0;
  localparam int unsigned LAY_B_T   = 1;
  localparam int unsigned LAY_OUT_T = 2;

  // Fixed-point format
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned ROUND_HALF = 128;
  localparam int unsigned CFG_W      = 16;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_word_t;

endpackage

@@ hw/rtl/gemm_alpha_beta_broadcast.sv @@
// Top level: alpha*(beta*C + A*B) over element stores held in three RAMs.
// Depends on gab_pkg and gab_ram.
//
//  channel  dir  handshake               word
//  in       in   in_valid_i/in_stall_o   gab_pkg::in_word_t (load A/B/C or read)
//  out      out  out_valid_o/out_stall_i gab_pkg::out_word_t (one per read)
//  cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// A read inside M by N goes through the C read and beta*C, then the inner loop over
// K, the clamped inner dimension: one 16x16 multiply-accumulate per cycle fed by the
// A and B RAM read ports, then two partial products for alpha, a sum and the
// round/saturate step. A read outside M by N goes straight to the output step and returns zero.
// Stores are not cleared by reset; reset sets the configuration registers to their defaults.
// A finished result waits in the output register; loads are still taken then.
module gemm_alpha_beta_broadcast #(
  parameter int unsigned MAX_M = 64,
  parameter int unsigned MAX_N = 64,
  parameter int unsigned MAX_K = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  gab_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gab_pkg::out_word_t        out_word_o,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [gab_pkg::CFG_W-1:0] cfg_data_i
);

  import gab_pkg::*;

  localparam int unsigned DepthA = MAX_M * MAX_K;
  localparam int unsigned DepthB = MAX_N * MAX_K;
  localparam int unsigned DepthC = MAX_M * MAX_N;
  localparam int unsigned AW = (DepthA > 1) ? $clog2(DepthA) : 1;
  localparam int unsigned BW = (DepthB > 1) ? $clog2(DepthB) : 1;
  localparam int unsigned CW = (DepthC > 1) ? $clog2(DepthC) : 1;
  localparam int unsigned MW = $clog2(MAX_M + 1);
  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned KW = $clog2(MAX_K + 1);
  // accumulator holds K+1 terms of at most 2^30 each
  localparam int unsigned AccW = 32 + KW;
  localparam int unsigned Split = 22;
  localparam int unsigned LoW = Split + 1 + 16;
  localparam int unsigned HiW = AccW - Split + 16;
  localparam int unsigned PW = AccW + 16;
  localparam int unsigned QW = PW - FRAC_SHIFT;
  localparam logic signed [QW-1:0] QMax = QW'(32'sh7fff_ffff);
  localparam logic signed [QW-1:0] QMin = QW'(32'sh8000_0000);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CRD  = 8'b0000_0010,
    S_CMUL = 8'b0000_0100,
    S_MAC  = 8'b0000_1000,
    S_ALO  = 8'b0001_0000,
    S_AHI  = 8'b0010_0000,
    S_SUM  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [15:0] alpha_q, beta_q;
  logic [6:0]         rows_q, cols_q, inner_q;
  logic [2:0]         cmode_q, layout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 16'sd256;
      beta_q   <= 16'sd256;
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
      inner_q  <= 7'd64;
      cmode_q  <= CM_NONE;
      layout_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA:  alpha_q  <= $signed(cfg_data_i);
        REG_BETA:   beta_q   <= $signed(cfg_data_i);
        REG_ROWS:   rows_q   <= cfg_data_i[6:0];
        REG_COLS:   cols_q   <= cfg_data_i[6:0];
        REG_INNER:  inner_q  <= cfg_data_i[6:0];
        REG_CMODE:  cmode_q  <= cfg_data_i[2:0];
        REG_LAYOUT: layout_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [MW-1:0] m_eff;
  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;

  always_comb begin
    if (rows_q == 7'd0) m_eff = MW'(1);
    else if (32'(rows_q) > MAX_M) m_eff = MW'(MAX_M);
    else m_eff = MW'(rows_q);
    if (cols_q == 7'd0) n_eff = NW'(1);
    else if (32'(cols_q) > MAX_N) n_eff = NW'(MAX_N);
    else n_eff = NW'(cols_q);
    if (inner_q == 7'd0) k_eff = KW'(1);
    else if (32'(inner_q) > MAX_K) k_eff = KW'(MAX_K);
    else k_eff = KW'(inner_q);
  end

  logic accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // load address mapping into canonical order
  logic [5:0]    la_i, la_k, lb_j, lb_k;
  logic          we_a, we_b, we_c;
  logic [AW-1:0] waddr_a;
  logic [BW-1:0] waddr_b;
  logic [CW-1:0] waddr_c;

  always_comb begin
    la_i = layout_q[LAY_A_T] ? in_word_i.col_index : in_word_i.row_index;
    la_k = layout_q[LAY_A_T] ? in_word_i.row_index : in_word_i.col_index;
    lb_j = layout_q[LAY_B_T] ? in_word_i.row_index : in_word_i.col_index;
    lb_k = layout_q[LAY_B_T] ? in_word_i.col_index : in_word_i.row_index;
    we_a = accept && (in_word_i.func == FUNC_LOAD_A)
           && (32'(la_i) < MAX_M) && (32'(la_k) < MAX_K);
    we_b = accept && (in_word_i.func == FUNC_LOAD_B)
           && (32'(lb_j) < MAX_N) && (32'(lb_k) < MAX_K);
    we_c = accept && (in_word_i.func == FUNC_LOAD_C)
           && (32'(in_word_i.row_index) < MAX_M) && (32'(in_word_i.col_index) < MAX_N);
    waddr_a = AW'(32'(la_i) * MAX_K + 32'(la_k));
    waddr_b = BW'(32'(lb_j) * MAX_K + 32'(lb_k));
    waddr_c = CW'(32'(in_word_i.row_index) * MAX_N + 32'(in_word_i.col_index));
  end

  // read coordinate decode
  logic [5:0]    rd_i, rd_j;
  logic          rd_out;
  logic          c_has_d;
  logic [CW-1:0] c_addr_d;

  always_comb begin
    rd_i   = layout_q[LAY_OUT_T] ? in_word_i.col_index : in_word_i.row_index;
    rd_j   = layout_q[LAY_OUT_T] ? in_word_i.row_index : in_word_i.col_index;
    rd_out = (32'(rd_i) >= 32'(m_eff)) || (32'(rd_j) >= 32'(n_eff));
    c_has_d = 1'b1;
    case (cmode_q)
      CM_SCALAR: c_addr_d = '0;
      CM_ROW:    c_addr_d = CW'(32'(rd_i) * MAX_N);
      CM_FULL:   c_addr_d = CW'(32'(rd_i) * MAX_N + 32'(rd_j));
      CM_COL:    c_addr_d = CW'(32'(rd_j));
      default: begin
        c_addr_d = '0;
        c_has_d  = 1'b0;
      end
    endcase
  end

  // per-read working registers
  logic [AW-1:0]           a_base_q;
  logic [BW-1:0]           b_base_q;
  logic [CW-1:0]           c_addr_q;
  logic                    c_has_q, zero_q;
  logic [KW-1:0]           kk_q, k_q;
  logic                    rdv_q, pv_q;
  logic signed [31:0]      prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [LoW-1:0]   plo_q;
  logic signed [HiW-1:0]   phi_q;
  logic signed [PW-1:0]    p_q;
  out_word_t               out_q;
  logic                    out_valid_q;

  // A and B RAM read addresses follow the inner index
  logic [AW-1:0] raddr_a;
  logic [BW-1:0] raddr_b;
  logic [15:0]   a_rdata, b_rdata, c_rdata;

  assign raddr_a = AW'(32'(a_base_q) + 32'(k_q));
  assign raddr_b = BW'(32'(b_base_q) + 32'(k_q));

  gab_ram #(.WIDTH(16), .DEPTH(DepthA)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (in_word_i.elem_value),
    .raddr_i (raddr_a),
    .rdata_o (a_rdata)
  );

  gab_ram #(.WIDTH(16), .DEPTH(DepthB)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (in_word_i.elem_value),
    .raddr_i (raddr_b),
    .rdata_o (b_rdata)
  );

  gab_ram #(.WIDTH(16), .DEPTH(DepthC)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr_c),
    .wdata_i (in_word_i.elem_value),
    .raddr_i (c_addr_q),
    .rdata_o (c_rdata)
  );

  // shared 16x16 multiplier: beta*C first, then A*B products
  logic signed [15:0] mul_x, mul_y;
  logic signed [31:0] prod_d;
  logic               issue;

  always_comb begin
    if (state_q == S_CMUL) begin
      mul_x = c_has_q ? $signed(c_rdata) : 16'sd0;
      mul_y = beta_q;
    end else begin
      mul_x = $signed(a_rdata);
      mul_y = $signed(b_rdata);
    end
    prod_d = mul_x * mul_y;
    issue  = (k_q < kk_q);
  end

  // round and saturate
  logic signed [QW-1:0] q_val;
  logic                 sat_hi, sat_lo;
  out_word_t            fin_word;
  logic                 fin_fire;

  always_comb begin
    q_val  = p_q[PW-1:FRAC_SHIFT];
    sat_hi = (q_val > QMax);
    sat_lo = (q_val < QMin);
    if (zero_q) begin
      fin_word.result_value = '0;
      fin_word.saturated    = 1'b0;
    end else if (sat_hi) begin
      fin_word.result_value = 32'sh7fff_ffff;
      fin_word.saturated    = 1'b1;
    end else if (sat_lo) begin
      fin_word.result_value = 32'sh8000_0000;
      fin_word.saturated    = 1'b1;
    end else begin
      fin_word.result_value = q_val[31:0];
      fin_word.saturated    = 1'b0;
    end
    fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdv_q   <= 1'b0;
      pv_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_word_i.func == FUNC_READ)) begin
            state_q <= rd_out ? S_FIN : S_CRD;
          end
        end
        S_CRD: begin
          k_q     <= '0;
          state_q <= S_CMUL;
        end
        S_CMUL: begin
          // inner index zero is being read now
          k_q     <= KW'(1);
          rdv_q   <= 1'b1;
          pv_q    <= 1'b1;
          state_q <= S_MAC;
        end
        S_MAC: begin
          pv_q  <= rdv_q;
          rdv_q <= issue;
          if (issue) k_q <= k_q + KW'(1);
          if (!issue && !rdv_q && !pv_q) state_q <= S_ALO;
        end
        S_ALO: state_q <= S_AHI;
        S_AHI: state_q <= S_SUM;
        S_SUM: state_q <= S_FIN;
        S_FIN: begin
          if (fin_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_base_q <= AW'(32'(rd_i) * MAX_K);
      b_base_q <= BW'(32'(rd_j) * MAX_K);
      c_addr_q <= c_addr_d;
      c_has_q  <= c_has_d;
      zero_q   <= rd_out;
      kk_q     <= k_eff;
    end
    case (state_q)
      S_CRD:  acc_q <= '0;
      S_CMUL: prod_q <= prod_d;
      S_MAC: begin
        prod_q <= prod_d;
        if (pv_q) acc_q <= acc_q + AccW'(prod_q);
      end
      S_ALO:  plo_q <= $signed({1'b0, acc_q[Split-1:0]}) * alpha_q;
      S_AHI:  phi_q <= $signed(acc_q[AccW-1:Split]) * alpha_q;
      S_SUM:  p_q <= (PW'(phi_q) <<< Split) + PW'(plo_q) + PW'(ROUND_HALF);
      default: ;
    endcase
    if (fin_fire) out_q <= fin_word;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hw/rtl/gab_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gab_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
